FILE: sv/nps_pkg.sv
// shared constants and types for the nice priority task scheduler
`default_nettype none
package nps_pkg;

    localparam int SLOTS     = 16;
    localparam int SLOT_W    = 4;
    localparam int PID_W     = 5;
    localparam int NICE_W    = 6;
    localparam int PRIO_W    = 6;
    localparam int SLICE_W   = 9;
    localparam int TOTAL_W   = 8;
    localparam int LIVE_W    = 5;
    localparam int DATA_W    = 32;
    localparam int LIMIT_W   = 8;
    localparam int ADDR_W    = 3;
    localparam int DIV_STEPS = 6;

    localparam logic signed [NICE_W-1:0] NICE_MAX = 6'sd19;
    localparam logic signed [NICE_W-1:0] NICE_MIN = -6'sd20;
    localparam logic [PRIO_W-1:0]        PRIO_CAP = 6'd39;
    localparam logic [LIMIT_W-1:0]       SLICE_RESET = 8'd10;
    localparam logic [SLICE_W-1:0]       SLICE_SAT = 9'd511;
    localparam logic [TOTAL_W-1:0]       TOTAL_SAT = 8'd255;

    localparam logic REG_SLICE_LIMIT = 1'b0;

    typedef enum logic [2:0] {
        OP_TICK = 3'd0,
        OP_FORK = 3'd1,
        OP_EXIT = 3'd2,
        OP_WAIT = 3'd3,
        OP_NICE = 3'd4
    } opcode_t;

    typedef enum logic [1:0] {
        TS_READY  = 2'd0,
        TS_RUN    = 2'd1,
        TS_SLEEP  = 2'd2,
        TS_ZOMBIE = 2'd3
    } task_state_t;

    typedef enum logic [1:0] {
        STS_DONE     = 2'd0,
        STS_FULL     = 2'd1,
        STS_NO_CHILD = 2'd2,
        STS_SLEPT    = 2'd3
    } status_t;

endpackage
`default_nettype wire

FILE: sv/nice_priority_task_scheduler.sv
// task table with nice based priority scheduler and iterative reschedule
// tick without reschedule, fork and set nice go straight to the done state; a wait that reaps
// passes through the reap state first; a reschedule walks every slot and runs the one shared
// 6 step divider for each used slot with nice above the floor
// one item at a time: in_stall is high from acceptance until the result is registered
// reset: slot zero running with parent one, all else clear, slice limit 10
`default_nettype none
module nice_priority_task_scheduler (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            in_valid,
    output logic                                 in_stall,
    input  wire logic [2:0]                      opcode,
    input  wire logic signed [nps_pkg::DATA_W-1:0] operand_value,
    output logic                                 out_valid,
    input  wire logic                            out_stall,
    output logic [1:0]                           status,
    output logic signed [nps_pkg::DATA_W-1:0]    result_value,
    output logic                                 switched,
    output logic [nps_pkg::PID_W-1:0]            running_pid,
    output logic [nps_pkg::PID_W-1:0]            running_parent_pid,
    output logic [nps_pkg::DATA_W-1:0]           tick_total,
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [nps_pkg::ADDR_W-1:0]      paddr,
    input  wire logic [nps_pkg::DATA_W-1:0]      pwdata,
    output logic [nps_pkg::DATA_W-1:0]           prdata,
    output logic                                 pready
);
    import nps_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_REAP,
        S_RS_PREP,
        S_RS_SLOT,
        S_RS_DIV,
        S_RS_PICK,
        S_RS_FIN,
        S_DONE
    } state_t;

    state_t                      state_reg;
    logic [LIMIT_W-1:0]          limit_reg;
    logic                        used_reg  [SLOTS];
    task_state_t                 ts_reg    [SLOTS];
    logic [PID_W-1:0]            parent_reg[SLOTS];
    logic signed [NICE_W-1:0]    nice_reg  [SLOTS];
    logic [PRIO_W-1:0]           prio_reg  [SLOTS];
    logic [SLICE_W-1:0]          slice_reg [SLOTS];
    logic [TOTAL_W-1:0]          total_reg [SLOTS];
    logic [DATA_W-1:0]           exit_mem  [SLOTS];
    logic [DATA_W-1:0]           exit_rd_reg;
    logic [SLOT_W-1:0]           cur_reg;
    logic [LIVE_W-1:0]           live_reg;
    logic [DATA_W-1:0]           tick_reg;

    logic [1:0]                  sts_reg;
    logic [DATA_W-1:0]           res_reg;
    logic                        sw_reg;
    logic [SLOT_W-1:0]           reap_reg;

    logic [SLOT_W-1:0]           idx_reg;
    logic [SLOT_W-1:0]           best_reg;
    logic [PRIO_W-1:0]           hi_reg;
    logic [PRIO_W-1:0]           num_reg;
    logic [SLICE_W-1:0]          den_reg;
    logic [SLICE_W-1:0]          rem_reg;
    logic [PRIO_W-1:0]           quo_reg;
    logic [2:0]                  cnt_reg;

    logic [1:0]                  out_sts_reg;
    logic [DATA_W-1:0]           out_res_reg;
    logic                        out_sw_reg;
    logic [PID_W-1:0]            out_pid_reg;
    logic [PID_W-1:0]            out_ppid_reg;
    logic [DATA_W-1:0]           out_tick_reg;
    logic                        out_valid_reg;

    logic                        in_fire;
    logic                        cfg_write;
    logic [PID_W-1:0]            my_pid;
    logic                        free_any;
    logic [SLOT_W-1:0]           free_idx;
    logic                        child_any;
    logic                        zombie_any;
    logic [SLOT_W-1:0]           zombie_idx;
    logic [SLICE_W-1:0]          slice_inc;
    logic [TOTAL_W-1:0]          total_inc;
    logic [PID_W-1:0]            par_pid;
    logic [SLOT_W-1:0]           par_slot;
    logic signed [NICE_W:0]      nice_sum;
    logic signed [NICE_W-1:0]    nice_raised;
    logic signed [NICE_W-1:0]    nice_req;
    logic signed [NICE_W-1:0]    nice_dec;
    logic [SLICE_W:0]            div_trial;
    logic                        div_bit;
    logic [SLICE_W-1:0]          div_rem;
    logic [PRIO_W-1:0]           div_quo;
    logic                        pick_elig;
    logic                        last_slot;

    assign in_fire   = in_valid && (state_reg == S_IDLE);
    assign in_stall  = (state_reg != S_IDLE);
    assign cfg_write = psel && penable && pwrite && pready;
    assign pready    = 1'b1;
    assign prdata    = (paddr[2] == REG_SLICE_LIMIT) ? {{(DATA_W-LIMIT_W){1'b0}}, limit_reg}
                                                     : '0;

    assign my_pid    = PID_W'({1'b0, cur_reg}) + PID_W'(1);
    assign last_slot = (idx_reg == SLOT_W'(SLOTS - 1));

    always_comb
    begin
        free_any   = 1'b0;
        free_idx   = '0;
        child_any  = 1'b0;
        zombie_any = 1'b0;
        zombie_idx = '0;
        for (int i = SLOTS - 1; i >= 0; i--)
        begin
            if (!used_reg[i])
            begin
                free_any = 1'b1;
                free_idx = SLOT_W'(i);
            end
            if (used_reg[i] && (SLOT_W'(i) != cur_reg) && (parent_reg[i] == my_pid))
            begin
                child_any = 1'b1;
                if (ts_reg[i] == TS_ZOMBIE)
                begin
                    zombie_any = 1'b1;
                    zombie_idx = SLOT_W'(i);
                end
            end
        end
    end

    always_comb
    begin
        slice_inc = (slice_reg[cur_reg] == SLICE_SAT) ? SLICE_SAT
                                                      : slice_reg[cur_reg] + SLICE_W'(1);
        total_inc = (total_reg[cur_reg] == TOTAL_SAT) ? TOTAL_SAT
                                                      : total_reg[cur_reg] + TOTAL_W'(1);
        par_pid   = parent_reg[cur_reg];
        par_slot  = SLOT_W'(par_pid - PID_W'(1));

        nice_sum    = {nice_reg[cur_reg][NICE_W-1], nice_reg[cur_reg]}
                    + $signed({2'b00, live_reg});
        nice_raised = (nice_sum > 7'sd19) ? NICE_MAX : nice_sum[NICE_W-1:0];

        if (operand_value > 32'sd19)
            nice_req = NICE_MAX;
        else if (operand_value < -32'sd20)
            nice_req = NICE_MIN;
        else
            nice_req = operand_value[NICE_W-1:0];

        nice_dec = nice_reg[idx_reg] - NICE_W'(1);

        div_trial = {rem_reg, num_reg[PRIO_W-1]};
        div_bit   = (div_trial >= {1'b0, den_reg});
        div_rem   = div_bit ? SLICE_W'(div_trial - {1'b0, den_reg}) : div_trial[SLICE_W-1:0];
        div_quo   = {quo_reg[PRIO_W-2:0], div_bit};

        pick_elig = used_reg[idx_reg]
                 && ((ts_reg[idx_reg] == TS_READY) || (ts_reg[idx_reg] == TS_RUN));
    end

    always_ff @(posedge clk)
    begin
        if (in_fire && (opcode == OP_EXIT))
            exit_mem[cur_reg] <= operand_value;
        exit_rd_reg <= exit_mem[zombie_idx];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            limit_reg     <= SLICE_RESET;
            for (int i = 0; i < SLOTS; i++)
            begin
                used_reg[i]   <= (i == 0);
                ts_reg[i]     <= (i == 0) ? TS_RUN : TS_READY;
                parent_reg[i] <= (i == 0) ? PID_W'(1) : '0;
                nice_reg[i]   <= '0;
                prio_reg[i]   <= '0;
                slice_reg[i]  <= '0;
                total_reg[i]  <= '0;
            end
            cur_reg       <= '0;
            live_reg      <= LIVE_W'(1);
            tick_reg      <= '0;
            sts_reg       <= STS_DONE;
            res_reg       <= '0;
            sw_reg        <= 1'b0;
            reap_reg      <= '0;
            idx_reg       <= '0;
            best_reg      <= '0;
            hi_reg        <= '0;
            num_reg       <= '0;
            den_reg       <= '0;
            rem_reg       <= '0;
            quo_reg       <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
            out_sts_reg   <= STS_DONE;
            out_res_reg   <= '0;
            out_sw_reg    <= 1'b0;
            out_pid_reg   <= '0;
            out_ppid_reg  <= '0;
            out_tick_reg  <= '0;
        end
        else
        begin
            if (cfg_write && (paddr[2] == REG_SLICE_LIMIT))
                limit_reg <= pwdata[LIMIT_W-1:0];

            if (out_valid_reg && !out_stall)
                out_valid_reg <= 1'b0;

            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_fire)
                    begin
                        sts_reg   <= STS_DONE;
                        res_reg   <= '0;
                        sw_reg    <= 1'b0;
                        state_reg <= S_DONE;
                        unique case (opcode)
                            OP_TICK:
                            begin
                                tick_reg           <= tick_reg + DATA_W'(1);
                                slice_reg[cur_reg] <= slice_inc;
                                total_reg[cur_reg] <= total_inc;
                                if (slice_inc > {1'b0, limit_reg})
                                begin
                                    sw_reg    <= 1'b1;
                                    state_reg <= S_RS_PREP;
                                end
                            end
                            OP_FORK:
                            begin
                                if (free_any)
                                begin
                                    used_reg[free_idx]   <= 1'b1;
                                    ts_reg[free_idx]     <= TS_READY;
                                    parent_reg[free_idx] <= my_pid;
                                    nice_reg[free_idx]   <= nice_reg[cur_reg];
                                    prio_reg[free_idx]   <= '0;
                                    slice_reg[free_idx]  <= slice_reg[cur_reg];
                                    total_reg[free_idx]  <= '0;
                                    live_reg             <= live_reg + LIVE_W'(1);
                                    res_reg <= DATA_W'({1'b0, free_idx}) + DATA_W'(1);
                                end
                                else
                                    sts_reg <= STS_FULL;
                            end
                            OP_EXIT:
                            begin
                                if ((ts_reg[cur_reg] != TS_ZOMBIE) && (live_reg != '0))
                                    live_reg <= live_reg - LIVE_W'(1);
                                ts_reg[cur_reg] <= TS_ZOMBIE;
                                if ((par_pid != '0) && (par_pid <= PID_W'(SLOTS))
                                    && (par_slot != cur_reg) && used_reg[par_slot]
                                    && (ts_reg[par_slot] == TS_SLEEP))
                                    ts_reg[par_slot] <= TS_READY;
                                sw_reg    <= 1'b1;
                                state_reg <= S_RS_PREP;
                            end
                            OP_WAIT:
                            begin
                                if (!child_any)
                                    sts_reg <= STS_NO_CHILD;
                                else if (zombie_any)
                                begin
                                    reap_reg  <= zombie_idx;
                                    state_reg <= S_REAP;
                                end
                                else
                                begin
                                    ts_reg[cur_reg] <= TS_SLEEP;
                                    sts_reg         <= STS_SLEPT;
                                    sw_reg          <= 1'b1;
                                    state_reg       <= S_RS_PREP;
                                end
                            end
                            OP_NICE:
                                nice_reg[cur_reg] <= nice_req;
                            default:
                                state_reg <= S_DONE;
                        endcase
                    end
                end
                S_REAP:
                begin
                    res_reg            <= exit_rd_reg;
                    used_reg[reap_reg] <= 1'b0;
                    ts_reg[reap_reg]   <= TS_READY;
                    state_reg          <= S_DONE;
                end
                S_RS_PREP:
                begin
                    if (ts_reg[cur_reg] == TS_RUN)
                        ts_reg[cur_reg] <= TS_READY;
                    nice_reg[cur_reg] <= nice_raised;
                    idx_reg   <= '0;
                    best_reg  <= cur_reg;
                    hi_reg    <= '0;
                    state_reg <= S_RS_SLOT;
                end
                S_RS_SLOT:
                begin
                    if (used_reg[idx_reg] && (nice_reg[idx_reg] > NICE_MIN))
                    begin
                        nice_reg[idx_reg] <= nice_dec;
                        num_reg   <= PRIO_W'(NICE_MAX - nice_dec);
                        den_reg   <= SLICE_W'({1'b0, total_reg[idx_reg]}) + SLICE_W'(1);
                        rem_reg   <= '0;
                        quo_reg   <= '0;
                        cnt_reg   <= '0;
                        state_reg <= S_RS_DIV;
                    end
                    else if (used_reg[idx_reg])
                        state_reg <= S_RS_PICK;
                    else if (last_slot)
                        state_reg <= S_RS_FIN;
                    else
                        idx_reg <= idx_reg + SLOT_W'(1);
                end
                S_RS_DIV:
                begin
                    rem_reg <= div_rem;
                    quo_reg <= div_quo;
                    num_reg <= {num_reg[PRIO_W-2:0], 1'b0};
                    cnt_reg <= cnt_reg + 3'd1;
                    if (cnt_reg == 3'(DIV_STEPS - 1))
                    begin
                        prio_reg[idx_reg] <= (div_quo > PRIO_CAP) ? PRIO_CAP : div_quo;
                        state_reg         <= S_RS_PICK;
                    end
                end
                S_RS_PICK:
                begin
                    if (pick_elig)
                    begin
                        if (prio_reg[idx_reg] > hi_reg)
                        begin
                            best_reg <= idx_reg;
                            hi_reg   <= prio_reg[idx_reg];
                        end
                        else if ((prio_reg[idx_reg] == hi_reg) && (idx_reg != cur_reg))
                            best_reg <= idx_reg;
                    end
                    if (last_slot)
                        state_reg <= S_RS_FIN;
                    else
                    begin
                        idx_reg   <= idx_reg + SLOT_W'(1);
                        state_reg <= S_RS_SLOT;
                    end
                end
                S_RS_FIN:
                begin
                    cur_reg             <= best_reg;
                    slice_reg[best_reg] <= '0;
                    if (ts_reg[best_reg] == TS_READY)
                        ts_reg[best_reg] <= TS_RUN;
                    state_reg <= S_DONE;
                end
                S_DONE:
                begin
                    if (!out_valid_reg || !out_stall)
                    begin
                        out_valid_reg <= 1'b1;
                        out_sts_reg   <= sts_reg;
                        out_res_reg   <= res_reg;
                        out_sw_reg    <= sw_reg;
                        out_pid_reg   <= my_pid;
                        out_ppid_reg  <= parent_reg[cur_reg];
                        out_tick_reg  <= tick_reg;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    assign out_valid          = out_valid_reg;
    assign status             = out_sts_reg;
    assign result_value       = out_res_reg;
    assign switched           = out_sw_reg;
    assign running_pid        = out_pid_reg;
    assign running_parent_pid = out_ppid_reg;
    assign tick_total         = out_tick_reg;

    // between items the running slot is a live table entry
    a_cur_used: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> used_reg[cur_reg])
        else $error("current slot not in use");

    // between items the current task is never left merely ready
    a_cur_not_ready: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> (ts_reg[cur_reg] != TS_READY))
        else $error("current task left ready");

    a_live_bound: assert property (@(posedge clk) disable iff (!rst_n)
        live_reg <= LIVE_W'(SLOTS))
        else $error("live count above table size");

    a_div_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RS_DIV) |-> (cnt_reg < 3'(DIV_STEPS)))
        else $error("divider ran past its steps");

    // a reschedule always ends in a registered result with switched set
    a_fin_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RS_FIN) |=> ((state_reg == S_DONE) && sw_reg))
        else $error("reschedule did not finish");

endmodule
`default_nettype wire
